// File: design/dual_number_alu_defines.svh
// Assertion macros shared by the dual number ALU.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef DUAL_NUMBER_ALU_DEFINES_SVH
`define DUAL_NUMBER_ALU_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DNA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dual number ALU check failed");

// next-cycle implication, disabled during reset
`define DNA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dual number ALU check failed");

`endif

// File: design/dna_pkg.sv
// Package for the dual number ALU: payload structs, operation and status codes.
// No dependencies.
package dna_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIELD_W        = 32;

  // operation codes
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [FIELD_W-1:0] a_real;
    logic signed [FIELD_W-1:0] a_dual;
    logic signed [FIELD_W-1:0] b_real;
    logic signed [FIELD_W-1:0] b_dual;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] res_real;
    logic signed [FIELD_W-1:0] res_dual;
    logic [1:0]                status;
  } out_t;

endpackage

// File: design/dual_number_alu.sv
// Dual number ALU: add, subtract, multiply, divide on Q-format dual numbers.
// Inputs pass through stage 1, divider set-up, the divider stages and the output register; one transaction per cycle.
// The divider resolves one quotient bit per pipeline stage.
// busy is always low; results leave on out_valid and cannot be held off.
// rst_n (synchronous) clears the valid bits only; no other state is kept.
module dual_number_alu #(
  parameter int DATA_WIDTH = dna_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = dna_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  dna_pkg::in_t in_data,
  output logic         out_valid,
  output dna_pkg::out_t out_data
);

  import dna_pkg::*;

`include "dual_number_alu_defines.svh"

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int PW  = 2 * DW;
  localparam int EW  = 2 * DW + 1;
  localparam int LAT = DW + 3;

  localparam logic signed [DW-1:0] POS_LIM = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] NEG_LIM = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [EW-1:0] POS_E   = EW'(POS_LIM);
  localparam logic signed [EW-1:0] NEG_E   = EW'(NEG_LIM);
  localparam logic [DW-1:0]        HALF    = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [DW-1:0] lin_re;   // add/sub/mul result, clamped
    logic signed [DW-1:0] lin_du;
    logic                 lin_ovf;
    logic                 dz;
    logic                 a_neg;
    logic                 qneg;
    logic                 dneg;
    logic                 big_re;
    logic                 big_du;
  } sb_t;

  // signed saturation of a divider magnitude: {ovf, value}
  function automatic logic [DW:0] sgn_sat(input logic neg, input logic big,
                                          input logic [DW-1:0] q);
    logic [DW:0] r;
    if (neg) begin
      if (big || q > HALF) r = {1'b1, NEG_LIM};
      else                 r = {1'b0, DW'(0) - q};
    end else begin
      if (big || q > POS_LIM) r = {1'b1, POS_LIM};
      else                    r = {1'b0, q};
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // ---------------- stage 1: operands and products ----------------
  logic signed [DW-1:0] a_in, ad_in, b_in, bd_in;
  logic signed [PW-1:0] pab_nxt, pabd_nxt, padb_nxt, pbb_nxt;
  logic                 v1_r;
  logic [1:0]           m1_r;
  logic signed [DW-1:0] a1_r, b1_r;
  logic signed [PW-1:0] pab1_r, pabd1_r, padb1_r, pbb1_r;
  logic signed [DW-1:0] ad1_r, bd1_r;

  assign a_in     = in_data.a_real[DW-1:0];
  assign ad_in    = in_data.a_dual[DW-1:0];
  assign b_in     = in_data.b_real[DW-1:0];
  assign bd_in    = in_data.b_dual[DW-1:0];
  assign pab_nxt  = PW'(a_in) * PW'(b_in);
  assign pabd_nxt = PW'(a_in) * PW'(bd_in);
  assign padb_nxt = PW'(ad_in) * PW'(b_in);
  assign pbb_nxt  = PW'(b_in) * PW'(b_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    m1_r    <= in_data.mode;
    a1_r    <= a_in;
    ad1_r   <= ad_in;
    b1_r    <= b_in;
    bd1_r   <= bd_in;
    pab1_r  <= pab_nxt;
    pabd1_r <= pabd_nxt;
    padb1_r <= padb_nxt;
    pbb1_r  <= pbb_nxt;
  end

  // ---------------- stage 2: linear results and divider set-up ----------------
  logic signed [EW-1:0]  lin_re_e, lin_du_e, ddif;
  logic                  dneg;
  logic [PW-1:0]         dmag;
  logic [DW-1:0]         amag, bmag;
  logic [DW+FB-1:0]      re_num;
  logic [PW+FB-1:0]      du_num;
  logic [DW-1:0]         re_rem0;
  logic [PW-1:0]         du_rem0;
  sb_t                   sb_nxt;

  always_comb begin
    unique case (m1_r)
      MODE_ADD: begin
        lin_re_e = EW'(a1_r) + EW'(b1_r);
        lin_du_e = EW'(ad1_r) + EW'(bd1_r);
      end
      MODE_SUB: begin
        lin_re_e = EW'(a1_r) - EW'(b1_r);
        lin_du_e = EW'(ad1_r) - EW'(bd1_r);
      end
      default: begin
        lin_re_e = EW'(pab1_r) >>> FB;
        lin_du_e = (EW'(padb1_r) + EW'(pabd1_r)) >>> FB;
      end
    endcase

    // numerator of the dual quotient: a'b - ab'
    dneg = padb1_r < pabd1_r;
    ddif = EW'(padb1_r) - EW'(pabd1_r);
    dmag = dneg ? PW'(-ddif) : PW'(ddif);
    amag = a1_r[DW-1] ? DW'(-a1_r) : DW'(a1_r);
    bmag = b1_r[DW-1] ? DW'(-b1_r) : DW'(b1_r);

    re_num  = {amag, {FB{1'b0}}};
    du_num  = {dmag, {FB{1'b0}}};
    re_rem0 = DW'(re_num[DW+FB-1:DW]);
    du_rem0 = PW'(du_num[PW+FB-1:DW]);

    sb_nxt.mode    = m1_r;
    sb_nxt.lin_ovf = 1'b0;
    if (lin_re_e > POS_E) begin
      sb_nxt.lin_re = POS_LIM; sb_nxt.lin_ovf = 1'b1;
    end else if (lin_re_e < NEG_E) begin
      sb_nxt.lin_re = NEG_LIM; sb_nxt.lin_ovf = 1'b1;
    end else begin
      sb_nxt.lin_re = DW'(lin_re_e);
    end
    if (lin_du_e > POS_E) begin
      sb_nxt.lin_du = POS_LIM; sb_nxt.lin_ovf = 1'b1;
    end else if (lin_du_e < NEG_E) begin
      sb_nxt.lin_du = NEG_LIM; sb_nxt.lin_ovf = 1'b1;
    end else begin
      sb_nxt.lin_du = DW'(lin_du_e);
    end
    sb_nxt.dz     = (b1_r == '0);
    sb_nxt.a_neg  = a1_r[DW-1];
    sb_nxt.qneg   = a1_r[DW-1] ^ b1_r[DW-1];
    sb_nxt.dneg   = dneg;
    // quotient would need more than DW bits
    sb_nxt.big_re = (re_rem0 >= bmag);
    sb_nxt.big_du = (du_rem0 >= PW'(pbb1_r));
  end

  logic [DW-1:0] re_rem [0:DW];
  logic [DW-1:0] re_den [0:DW];
  logic [DW-1:0] re_nq  [0:DW];
  logic [PW-1:0] du_rem [0:DW];
  logic [PW-1:0] du_den [0:DW];
  logic [DW-1:0] du_nq  [0:DW];
  sb_t           sb_r   [0:DW];
  logic          vs_r   [0:DW];
  logic [DW-1:0] re_rem0_r, re_den0_r, re_nq0_r, du_nq0_r;
  logic [PW-1:0] du_rem0_r, du_den0_r;

  always_ff @(posedge clk) begin
    re_rem0_r <= re_rem0;
    re_den0_r <= bmag;
    re_nq0_r  <= re_num[DW-1:0];
    du_rem0_r <= du_rem0;
    du_den0_r <= PW'(pbb1_r);
    du_nq0_r  <= du_num[DW-1:0];
    sb_r[0]   <= sb_nxt;
  end

  assign re_rem[0] = re_rem0_r;
  assign re_den[0] = re_den0_r;
  assign re_nq[0]  = re_nq0_r;
  assign du_rem[0] = du_rem0_r;
  assign du_den[0] = du_den0_r;
  assign du_nq[0]  = du_nq0_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DW; i++) vs_r[i] <= 1'b0;
    end else begin
      vs_r[0] <= v1_r;
      for (int i = 1; i <= DW; i++) vs_r[i] <= vs_r[i-1];
    end
  end

  // ---------------- divider stages: one quotient bit each ----------------
  for (genvar k = 0; k < DW; k++) begin : g_div
    dna_div_step #(.RW(DW), .QW(DW)) u_re (
      .clk  (clk),
      .rem_i(re_rem[k]), .den_i(re_den[k]), .nq_i(re_nq[k]),
      .rem_o(re_rem[k+1]), .den_o(re_den[k+1]), .nq_o(re_nq[k+1])
    );
    dna_div_step #(.RW(PW), .QW(DW)) u_du (
      .clk  (clk),
      .rem_i(du_rem[k]), .den_i(du_den[k]), .nq_i(du_nq[k]),
      .rem_o(du_rem[k+1]), .den_o(du_den[k+1]), .nq_o(du_nq[k+1])
    );
    always_ff @(posedge clk) begin
      sb_r[k+1] <= sb_r[k];
    end
  end

  // ---------------- final stage: saturate and register the result ----------------
  sb_t                  sb_l;
  logic [DW:0]          sat_re, sat_du;
  logic signed [DW-1:0] fin_re, fin_du;
  logic [1:0]           fin_st;
  logic                 out_valid_r;
  out_t                 out_r;

  assign sb_l = sb_r[DW];

  always_comb begin
    sat_re = sgn_sat(sb_l.qneg, sb_l.big_re, re_nq[DW]);
    sat_du = sgn_sat(sb_l.dneg, sb_l.big_du, du_nq[DW]);
    if (sb_l.mode != MODE_DIV) begin
      fin_re = sb_l.lin_re;
      fin_du = sb_l.lin_du;
      fin_st = sb_l.lin_ovf ? ST_OVF : ST_OK;
    end else if (sb_l.dz) begin
      fin_re = sb_l.a_neg ? NEG_LIM : POS_LIM;
      fin_du = sb_l.dneg ? NEG_LIM : POS_LIM;
      fin_st = ST_DZ;
    end else begin
      fin_re = sat_re[DW-1:0];
      fin_du = sat_du[DW-1:0];
      fin_st = (sat_re[DW] || sat_du[DW]) ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vs_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    out_r.res_real <= FIELD_W'(fin_re);
    out_r.res_dual <= FIELD_W'(fin_du);
    out_r.status   <= fin_st;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- checks ----------------
  // divide with a zero real divisor on the input side
  logic in_dz_div;
  assign in_dz_div = (in_data.mode == MODE_DIV) && (in_data.b_real[DW-1:0] == '0);

  `DNA_ASSERT_IMP(a_out_has_src, out_valid, $past(start, LAT))
  `DNA_ASSERT_IMP(a_dz_only_div, out_valid && out_data.status == ST_DZ, $past(in_dz_div, LAT))
  `DNA_ASSERT_NXT(a_lin_no_dz, vs_r[DW] && sb_l.mode != MODE_DIV, out_data.status != ST_DZ)

endmodule

// File: design/dna_div_step.sv
// One registered step of a restoring divider: one quotient bit per stage.
// Depends on nothing; instanced per stage by dual_number_alu.
module dna_div_step #(
  parameter int RW = 32,  // remainder / divisor width
  parameter int QW = 32   // dividend low bits, becoming the quotient
) (
  input  logic          clk,
  input  logic [RW-1:0] rem_i,
  input  logic [RW-1:0] den_i,
  input  logic [QW-1:0] nq_i,
  output logic [RW-1:0] rem_o,
  output logic [RW-1:0] den_o,
  output logic [QW-1:0] nq_o
);

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] nq_nxt;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] den_r;
  logic [QW-1:0] nq_r;

  // bring down the next dividend bit and try the subtraction
  always_comb begin
    trial   = {rem_i, nq_i[QW-1]};
    diff    = trial - {1'b0, den_i};
    ge      = (trial >= {1'b0, den_i});
    rem_nxt = ge ? diff[RW-1:0] : trial[RW-1:0];
    nq_nxt  = {nq_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_i;
    nq_r  <= nq_nxt;
  end

  assign rem_o = rem_r;
  assign den_o = den_r;
  assign nq_o  = nq_r;

endmodule
